[rtl/assert_macros.svh]
// assertion macros used by sorted_set_table
// depends on nothing; concurrent checks compile away when SYNTHESIS is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked on a named clock with an active-low reset
`define ASSERT_CLKRST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// property checked on the block's own clock and reset
`define ASSERT_IMPL(lbl, prop, msg) `ASSERT_CLKRST(lbl, clk_i, rst_ni, prop, msg)
`else
`define ASSERT_CLKRST(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPL(lbl, prop, msg)
`endif
`endif

[rtl/sst_pkg.sv]
// sorted set table package: sizes, operation and status codes, microcode rom
// used by sorted_set_table; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package sst_pkg;

  // store size and derived widths
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;
  localparam int KIND_W   = 2;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;
  localparam int OUT_W    = 8;

  // operation codes carried in tuser
  localparam logic [KIND_W-1:0] K_ADD   = 2'd0;
  localparam logic [KIND_W-1:0] K_DEL   = 2'd1;
  localparam logic [KIND_W-1:0] K_CHECK = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOCHG = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // microprogram addresses
  typedef enum logic [3:0] {
    UA_IDLE   = 4'd0,
    UA_SRCH   = 4'd1,
    UA_DISP_A = 4'd2,
    UA_DISP_D = 4'd3,
    UA_RES    = 4'd4,
    UA_UP0    = 4'd5,
    UA_UP1    = 4'd6,
    UA_INS    = 4'd7,
    UA_DN0    = 4'd8,
    UA_DN1    = 4'd9,
    UA_DNE    = 4'd10
  } uc_addr_e;

  // branch conditions
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_ACCEPT,
    C_LT,
    C_ADD_INS,
    C_DEL_HIT,
    C_AT_POS,
    C_NXT_LAST,
    C_OUT_BUSY
  } cond_e;

  // pointer update
  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_INC_LT,
    PTR_INC,
    PTR_DEC,
    PTR_CNT
  } ptr_op_e;

  // memory read address relative to the next pointer
  typedef enum logic [1:0] {
    RA_PTR,
    RA_PTR_M1,
    RA_PTR_P1
  } ra_sel_e;

  // memory write source
  typedef enum logic [1:0] {
    WR_NONE,
    WR_SHIFT,
    WR_VALUE
  } wr_op_e;

  // element count update
  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  // one control word
  typedef struct packed {
    uc_addr_e tgt_t;
    uc_addr_e tgt_f;
    cond_e    cond;
    ptr_op_e  ptr_op;
    ra_sel_e  ra_sel;
    wr_op_e   wr_op;
    cnt_op_e  cnt_op;
    logic     in_ready;
    logic     ld_item;
    logic     cap_present;
    logic     cap_status;
    logic     out_load;
  } uc_word_t;

  // microprogram rom
  function automatic uc_word_t uc_rom(input uc_addr_e a);
    uc_word_t w;
    w = '0;
    w.tgt_t = UA_IDLE;
    w.tgt_f = UA_IDLE;
    case (a)
      UA_IDLE: begin
        // wait for an item, then start the search at entry zero
        w.in_ready = 1'b1;
        w.ld_item  = 1'b1;
        w.ptr_op   = PTR_ZERO;
        w.ra_sel   = RA_PTR;
        w.cond     = C_NO_ACCEPT;
        w.tgt_t    = UA_IDLE;
        w.tgt_f    = UA_SRCH;
      end
      UA_SRCH: begin
        // one entry per cycle until the first entry not below the value, or the end of the set
        w.ptr_op      = PTR_INC_LT;
        w.ra_sel      = RA_PTR;
        w.cap_present = 1'b1;
        w.cond        = C_LT;
        w.tgt_t       = UA_SRCH;
        w.tgt_f       = UA_DISP_A;
      end
      UA_DISP_A: begin
        w.cap_status = 1'b1;
        w.cond       = C_ADD_INS;
        w.tgt_t      = UA_UP0;
        w.tgt_f      = UA_DISP_D;
      end
      UA_DISP_D: begin
        w.ra_sel = RA_PTR_P1;
        w.cond   = C_DEL_HIT;
        w.tgt_t  = UA_DN0;
        w.tgt_f  = UA_RES;
      end
      UA_RES: begin
        w.out_load = 1'b1;
        w.cond     = C_OUT_BUSY;
        w.tgt_t    = UA_RES;
        w.tgt_f    = UA_IDLE;
      end
      UA_UP0: begin
        // start the upward shift at the top of the set
        w.ptr_op = PTR_CNT;
        w.ra_sel = RA_PTR_M1;
        w.cond   = C_AT_POS;
        w.tgt_t  = UA_INS;
        w.tgt_f  = UA_UP1;
      end
      UA_UP1: begin
        w.wr_op  = WR_SHIFT;
        w.ptr_op = PTR_DEC;
        w.ra_sel = RA_PTR_M1;
        w.cond   = C_AT_POS;
        w.tgt_t  = UA_INS;
        w.tgt_f  = UA_UP1;
      end
      UA_INS: begin
        w.wr_op  = WR_VALUE;
        w.cnt_op = CNT_INC;
        w.cond   = C_ALWAYS;
        w.tgt_t  = UA_RES;
      end
      UA_DN0: begin
        // entry above the hit is being read; skip the shift for the top entry
        w.ra_sel = RA_PTR_P1;
        w.cond   = C_NXT_LAST;
        w.tgt_t  = UA_DNE;
        w.tgt_f  = UA_DN1;
      end
      UA_DN1: begin
        w.wr_op  = WR_SHIFT;
        w.ptr_op = PTR_INC;
        w.ra_sel = RA_PTR_P1;
        w.cond   = C_NXT_LAST;
        w.tgt_t  = UA_DNE;
        w.tgt_f  = UA_DN1;
      end
      UA_DNE: begin
        w.cnt_op = CNT_DEC;
        w.cond   = C_ALWAYS;
        w.tgt_t  = UA_RES;
      end
      default: begin
        w.cond  = C_ALWAYS;
        w.tgt_t = UA_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[rtl/sorted_set_table.sv]
// Sorted set table: holds up to CAPACITY distinct signed 32-bit values in
// ascending order in a single-port-read element memory and serves one add,
// delete or membership check per input item, returning one result item with
// the prior membership, the new count and a status code. A short microcode
// program steps the search and the shift one entry per cycle; the one read
// port of the element memory sets this pace. A finished result waits in an
// output register while the next item is taken. Memory contents are
// undefined after reset and need no clearing; entries at or above the count
// may be read, but their data is never used.
// depends on sst_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sorted_set_table
  import sst_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input items
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [VALUE_W-1:0]  s_axis_tdata_i,   // [31:0] value
  input  wire logic [KIND_W-1:0]   s_axis_tuser_i,   // [1:0] kind
  // result items
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic [OUT_W-1:0]         m_axis_tdata_o    // [0] was_present, [5:1] count,
                                                     // [7:6] status
);

  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CAPACITY);

  // sequencer and datapath registers
  uc_addr_e              upc_q, upc_d;
  logic [CNT_W-1:0]      ptr_q, ptr_d;
  logic [CNT_W-1:0]      pos_q;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [KIND_W-1:0]     kind_q;
  logic [VALUE_W-1:0]    value_q;
  logic                  present_q;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic                  out_valid_q;
  logic [OUT_W-1:0]      out_data_q;

  // element memory
  logic [VALUE_W-1:0]    mem [CAPACITY];
  logic [VALUE_W-1:0]    rdata_q;
  logic [CNT_W-1:0]      ra_full;
  logic [CNT_W-1:0]      wa_full;
  logic [IDX_W-1:0]      ra;
  logic [IDX_W-1:0]      wa;
  logic [VALUE_W-1:0]    wd;
  logic                  wr_en;

  uc_word_t              uw;
  logic                  in_fire;
  logic                  lt;
  logic                  hit;
  logic                  out_busy;
  logic                  cond_true;

  // current control word
  assign uw       = uc_rom(upc_q);
  assign in_fire  = s_axis_tvalid_i && uw.in_ready;
  assign out_busy = out_valid_q && !m_axis_tready_i;

  // search compare on the entry read last cycle
  assign lt  = (ptr_q < cnt_q) && ($signed(rdata_q) < $signed(value_q));
  assign hit = (ptr_q < cnt_q) && (rdata_q == value_q);

  // pointer update
  always_comb begin
    case (uw.ptr_op)
      PTR_HOLD:   ptr_d = ptr_q;
      PTR_ZERO:   ptr_d = '0;
      PTR_INC_LT: ptr_d = lt ? ptr_q + CNT_ONE : ptr_q;
      PTR_INC:    ptr_d = ptr_q + CNT_ONE;
      PTR_DEC:    ptr_d = ptr_q - CNT_ONE;
      PTR_CNT:    ptr_d = cnt_q;
      default:    ptr_d = ptr_q;
    endcase
  end

  // branch condition and next step
  always_comb begin
    case (uw.cond)
      C_ALWAYS:    cond_true = 1'b1;
      C_NO_ACCEPT: cond_true = !in_fire;
      C_LT:        cond_true = lt;
      C_ADD_INS:   cond_true = (kind_q == K_ADD) && !present_q && (cnt_q < CNT_CAP);
      C_DEL_HIT:   cond_true = (kind_q == K_DEL) && present_q;
      C_AT_POS:    cond_true = (ptr_d == pos_q);
      C_NXT_LAST:  cond_true = ((ptr_d + CNT_ONE) == cnt_q);
      C_OUT_BUSY:  cond_true = out_busy;
      default:     cond_true = 1'b1;
    endcase
    upc_d = cond_true ? uw.tgt_t : uw.tgt_f;
  end

  // count update
  always_comb begin
    case (uw.cnt_op)
      CNT_HOLD: cnt_d = cnt_q;
      CNT_INC:  cnt_d = cnt_q + CNT_ONE;
      CNT_DEC:  cnt_d = cnt_q - CNT_ONE;
      default:  cnt_d = cnt_q;
    endcase
  end

  // status from the operation, prior membership and fill level
  always_comb begin
    if (kind_q == K_ADD) begin
      if (present_q) begin
        status_d = ST_NOCHG;
      end else if (cnt_q >= CNT_CAP) begin
        status_d = ST_FULL;
      end else begin
        status_d = ST_DONE;
      end
    end else if (kind_q == K_DEL) begin
      status_d = present_q ? ST_DONE : ST_NOCHG;
    end else begin
      status_d = ST_DONE;
    end
  end

  // memory addresses and write data
  always_comb begin
    case (uw.ra_sel)
      RA_PTR:    ra_full = ptr_d;
      RA_PTR_M1: ra_full = ptr_d - CNT_ONE;
      RA_PTR_P1: ra_full = ptr_d + CNT_ONE;
      default:   ra_full = ptr_d;
    endcase
    wr_en   = (uw.wr_op != WR_NONE);
    wa_full = (uw.wr_op == WR_VALUE) ? pos_q : ptr_q;
    wd      = (uw.wr_op == WR_VALUE) ? value_q : rdata_q;
  end

  assign ra = ra_full[IDX_W-1:0];
  assign wa = wa_full[IDX_W-1:0];

  // element memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wa] <= wd;
    end
    rdata_q <= mem[ra];
  end

  // sequencer state, datapath and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= UA_IDLE;
      ptr_q       <= '0;
      pos_q       <= '0;
      cnt_q       <= '0;
      kind_q      <= K_CHECK;
      value_q     <= '0;
      present_q   <= 1'b0;
      status_q    <= ST_DONE;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      upc_q <= upc_d;
      ptr_q <= ptr_d;
      cnt_q <= cnt_d;
      if (uw.ld_item && in_fire) begin
        kind_q  <= s_axis_tuser_i;
        value_q <= s_axis_tdata_i;
      end
      if (uw.cap_present) begin
        present_q <= hit;
        pos_q     <= ptr_q;
      end
      if (uw.cap_status) begin
        status_q <= status_d;
      end
      if (uw.out_load && !out_busy) begin
        out_valid_q <= 1'b1;
        out_data_q  <= {status_q, COUNT_W'(cnt_q), present_q};
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign s_axis_tready_o = uw.in_ready;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // checks on the sequencer and datapath
  `ASSERT_IMPL(a_accept_starts_search, in_fire |=> (upc_q == UA_SRCH), "item not searched")
  `ASSERT_IMPL(a_count_bounded, cnt_q <= CNT_CAP, "count above capacity")
  `ASSERT_IMPL(a_count_steps, cnt_q != $past(cnt_q) |-> $past(uw.cnt_op != CNT_HOLD), "stray count")
  `ASSERT_IMPL(a_write_in_range, wr_en |-> (wa_full < CNT_CAP), "write beyond store")
  `ASSERT_IMPL(a_result_held, out_busy |=> (out_valid_q && $stable(out_data_q)), "result not held")

endmodule

`default_nettype wire
